>>> rtl/rtps_pkg.sv
// shared types, constants and helpers of the release-time priority task scheduler
`default_nettype none

package rtps_pkg;

	// table size and derived widths
	localparam int MAX_TASKS = 16;
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int POS_W = 4;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int TC_W = 5;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TASKS - 1);

	// command codes
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOPOS = 2'd2
	} status_t;

	// per-entry task state
	typedef enum logic [1:0] {
		ST_DORMANT   = 2'd0,
		ST_READY     = 2'd1,
		ST_SUSPENDED = 2'd2,
		ST_RUNNING   = 2'd3
	} task_state_t;

	// configuration register index (paddr[2])
	typedef enum logic {
		REG_LIMIT = 1'b0,
		REG_STEP  = 1'b1
	} reg_idx_t;

	// operation broadcast to the cell row
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_TICK  = 3'd1,
		OP_ADD   = 3'd2,
		OP_SHIFT = 3'd3,
		OP_SCAN  = 3'd4,
		OP_WIN   = 3'd5
	} cell_op_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  priority_req;
		logic [15:0] release_time;
		logic [15:0] period;
		logic        runnable;
		logic [3:0]  position;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  selected_position;
		logic        selected_valid;
		logic        switch_request;
		logic [4:0]  task_count;
		task_state_t task_state_code;
		logic [15:0] remaining_time;
	} rsp_t;

	typedef struct packed {
		logic [7:0] limit;
		logic [7:0] step;
	} cfg_t;

	// one table entry as held by a cell
	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] rel_cnt;
		logic [15:0] period;
		logic        runnable;
		task_state_t state;
	} entry_t;

	// control word from the sequencer to every cell
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] sel;
		logic [CNT_W-1:0] count;
		logic             run_win;
		logic [7:0]       limit;
		logic [7:0]       step;
		entry_t           add_entry;
	} cell_ctl_t;

	// running best candidate handed down the row
	typedef struct packed {
		logic             found;
		logic [7:0]       prio;
		logic [IDX_W-1:0] idx;
	} best_t;

	function automatic logic [IDX_W-1:0] cell_index(input int g);
		return IDX_W'(g);
	endfunction

	function automatic logic [CNT_W-1:0] idx_to_cnt(input logic [IDX_W-1:0] i);
		return CNT_W'(i);
	endfunction

	function automatic logic [IDX_W-1:0] cnt_to_idx(input logic [CNT_W-1:0] c);
		return IDX_W'(c);
	endfunction

	function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] p);
		return IDX_W'(p);
	endfunction

	function automatic logic [POS_W-1:0] idx_to_pos(input logic [IDX_W-1:0] i);
		return POS_W'(i);
	endfunction

	function automatic logic [TC_W-1:0] cnt_to_tc(input logic [CNT_W-1:0] c);
		return TC_W'(c);
	endfunction

	// position lies inside the occupied part of the table
	function automatic logic pos_lt_count(input logic [POS_W-1:0] p,
			input logic [CNT_W-1:0] c);
		return CMP_W'(p) < CMP_W'(c);
	endfunction

endpackage

`default_nettype wire

>>> rtl/rtps_if.sv
// request and response channel interfaces of the task scheduler
`default_nettype none

interface rtps_req_if;
	logic          valid;
	logic          ready;
	rtps_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtps_rsp_if;
	logic          valid;
	logic          ready;
	rtps_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/release_time_priority_task_scheduler.sv
// top level: command sequencer, task registers and the row of entry cells
//
//   channel  dir  handshake          word
//   req      in   valid/ready        cmd, priority_req, release_time, period, runnable, position
//   rsp      out  valid/ready        status, selected_position, ... remaining_time
//   apb      in   psel/penable       lowest_priority_level @0x0, tick_step @0x4
//
// add, delete and query pass from accept through S_EXEC and S_RESP to the response
// word; a tick also runs S_SCAN and S_FIN, the best-candidate search walking the
// cell row one cell per cycle. one command is in flight at a time; a new word
// is taken while the previous response still waits in the output register.
// arst_n clears the table (count 0), both task registers and the output valid.
`default_nettype none

module release_time_priority_task_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rtps_req_if.sink                           req,
	rtps_rsp_if.source                         rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rtps_pkg::APB_AW-1:0]   paddr,
	input  wire logic [rtps_pkg::APB_DW-1:0]   pwdata,
	output logic      [rtps_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FIN,
		S_RESP
	} fsm_t;

	fsm_t                          state_q;
	logic [rtps_pkg::IDX_W-1:0]    scan_q;
	logic [rtps_pkg::CNT_W-1:0]    count_q;
	logic                          nxt_v_q;
	logic [rtps_pkg::IDX_W-1:0]    nxt_idx_q;
	logic                          cur_v_q;
	logic [rtps_pkg::IDX_W-1:0]    cur_idx_q;
	rtps_pkg::req_t                req_q;
	rtps_pkg::rsp_t                res_q;
	rtps_pkg::rsp_t                out_q;
	logic                          out_v_q;

	rtps_pkg::cfg_t                cfg;
	rtps_pkg::cell_ctl_t           ctl;
	rtps_pkg::entry_t              entries [rtps_pkg::MAX_TASKS];
	rtps_pkg::best_t               best_chain [rtps_pkg::MAX_TASKS+1];
	rtps_pkg::best_t               best;

	logic [rtps_pkg::CNT_W-1:0]    count_d;
	logic                          nxt_v_d;
	logic [rtps_pkg::IDX_W-1:0]    nxt_idx_d;
	logic                          cur_v_d;
	logic [rtps_pkg::IDX_W-1:0]    cur_idx_d;
	rtps_pkg::rsp_t                res_d;
	logic                          sel_from_next;
	logic [rtps_pkg::IDX_W-1:0]    pos_idx;
	logic                          pos_ok;
	logic                          out_free;

	// configuration registers
	rtps_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// row of cells; best candidate enters at cell 0 empty
	assign best_chain[0] = '0;

	for (genvar g = 0; g < rtps_pkg::MAX_TASKS; g++) begin : g_cell
		rtps_pkg::entry_t nbr;
		if (g == rtps_pkg::MAX_TASKS - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = entries[g+1];
		end
		rtps_cell u_cell (
			.clk      (clk),
			.cell_idx (rtps_pkg::cell_index(g)),
			.ctl      (ctl),
			.nbr      (nbr),
			.best_in  (best_chain[g]),
			.entry    (entries[g]),
			.best_out (best_chain[g+1])
		);
	end

	assign best     = best_chain[rtps_pkg::MAX_TASKS];
	assign pos_idx  = rtps_pkg::pos_to_idx(req_q.position);
	assign pos_ok   = rtps_pkg::pos_lt_count(req_q.position, count_q);
	assign out_free = !out_v_q || rsp.ready;

	// command decode, cell control and next values of the task registers
	always_comb begin
		ctl                    = '0;
		ctl.op                 = rtps_pkg::OP_NONE;
		ctl.count              = count_q;
		ctl.limit              = cfg.limit;
		ctl.step               = cfg.step;
		ctl.add_entry.prio     = req_q.priority_req;
		ctl.add_entry.rel_cnt  = req_q.release_time;
		ctl.add_entry.period   = req_q.period;
		ctl.add_entry.runnable = req_q.runnable;
		ctl.add_entry.state    = rtps_pkg::ST_DORMANT;
		count_d                = count_q;
		nxt_v_d                = nxt_v_q;
		nxt_idx_d              = nxt_idx_q;
		cur_v_d                = cur_v_q;
		cur_idx_d              = cur_idx_q;
		res_d                  = '0;
		sel_from_next          = 1'b1;

		unique case (state_q)
			S_EXEC: begin
				unique case (req_q.cmd)
					rtps_pkg::CMD_TICK: begin
						ctl.op = rtps_pkg::OP_TICK;
					end
					rtps_pkg::CMD_ADD: begin
						sel_from_next = 1'b0;
						if (count_q == rtps_pkg::FULL_CNT) begin
							res_d.status = rtps_pkg::STAT_FULL;
						end else begin
							ctl.op  = rtps_pkg::OP_ADD;
							ctl.sel = rtps_pkg::cnt_to_idx(count_q);
							count_d = count_q + 1'b1;
							res_d.selected_position =
								rtps_pkg::idx_to_pos(rtps_pkg::cnt_to_idx(count_q));
						end
					end
					rtps_pkg::CMD_DELETE: begin
						if (!pos_ok) begin
							res_d.status = rtps_pkg::STAT_NOPOS;
						end else begin
							ctl.op  = rtps_pkg::OP_SHIFT;
							ctl.sel = pos_idx;
							count_d = count_q - 1'b1;
							// task registers follow the entries down
							if (nxt_v_q) begin
								if (nxt_idx_q == pos_idx) begin
									nxt_v_d   = 1'b0;
									nxt_idx_d = '0;
								end else if (nxt_idx_q > pos_idx) begin
									nxt_idx_d = nxt_idx_q - 1'b1;
								end
							end
							if (cur_v_q) begin
								if (cur_idx_q == pos_idx) begin
									cur_v_d   = 1'b0;
									cur_idx_d = '0;
								end else if (cur_idx_q > pos_idx) begin
									cur_idx_d = cur_idx_q - 1'b1;
								end
							end
						end
					end
					rtps_pkg::CMD_QUERY: begin
						if (!pos_ok) begin
							res_d.status = rtps_pkg::STAT_NOPOS;
						end else begin
							res_d.task_state_code = entries[pos_idx].state;
							res_d.remaining_time  = entries[pos_idx].rel_cnt;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				ctl.op  = rtps_pkg::OP_SCAN;
				ctl.sel = scan_q;
			end
			S_FIN: begin
				// winner reload and context switch
				if (best.found) begin
					ctl.op    = rtps_pkg::OP_WIN;
					ctl.sel   = best.idx;
					nxt_v_d   = 1'b1;
					nxt_idx_d = best.idx;
					if (!cur_v_q || cur_idx_q != best.idx) begin
						ctl.run_win          = 1'b1;
						res_d.switch_request = 1'b1;
						cur_v_d              = 1'b1;
						cur_idx_d            = best.idx;
					end
				end
			end
			default: begin
			end
		endcase

		if (sel_from_next) begin
			res_d.selected_position = nxt_v_d ? rtps_pkg::idx_to_pos(nxt_idx_d) : 4'd0;
		end
		res_d.selected_valid = nxt_v_d;
		res_d.task_count     = rtps_pkg::cnt_to_tc(count_d);
	end

	// sequencer state, task registers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_q    <= '0;
			count_q   <= '0;
			nxt_v_q   <= 1'b0;
			nxt_idx_q <= '0;
			cur_v_q   <= 1'b0;
			cur_idx_q <= '0;
			req_q     <= '0;
			res_q     <= '0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			// output word taken; a new word loaded in S_RESP overrides this
			if (out_v_q && rsp.ready && state_q != S_RESP) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q   <= req.data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q   <= count_d;
					nxt_v_q   <= nxt_v_d;
					nxt_idx_q <= nxt_idx_d;
					cur_v_q   <= cur_v_d;
					cur_idx_q <= cur_idx_d;
					res_q     <= res_d;
					scan_q    <= '0;
					state_q   <= (req_q.cmd == rtps_pkg::CMD_TICK) ? S_SCAN : S_RESP;
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == rtps_pkg::IDX_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					nxt_v_q   <= nxt_v_d;
					nxt_idx_q <= nxt_idx_d;
					cur_v_q   <= cur_v_d;
					cur_idx_q <= cur_idx_d;
					res_q     <= res_d;
					state_q   <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_q   <= res_q;
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// table never holds more entries than cells
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rtps_pkg::FULL_CNT)
		else $error("task count beyond table size");

	// current and next task registers always name the same entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q == nxt_v_q) && (!cur_v_q || cur_idx_q == nxt_idx_q))
		else $error("current and next task registers disagree");

	// a switch is only reported with a selected task
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.switch_request |-> rsp.data.selected_valid)
		else $error("switch without selected task");

	// search ends after the last cell
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && (scan_q == rtps_pkg::IDX_LAST) |=> state_q == S_FIN)
		else $error("search did not finish after last cell");

	// one command in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second word taken while busy");

endmodule

`default_nettype wire

>>> rtl/rtps_cell.sv
// one table entry cell: holds an entry, updates it on ticks, joins the best search
`default_nettype none

module rtps_cell (
	input  wire logic                          clk,
	input  wire logic [rtps_pkg::IDX_W-1:0]    cell_idx,
	input  wire rtps_pkg::cell_ctl_t           ctl,
	input  wire rtps_pkg::entry_t              nbr,
	input  wire rtps_pkg::best_t               best_in,
	output rtps_pkg::entry_t                   entry,
	output rtps_pkg::best_t                    best_out
);

	rtps_pkg::entry_t entry_q;
	rtps_pkg::best_t  best_q;
	logic             cand_q;
	logic             occ;
	logic             hit;
	logic             is_zero;
	logic             cand_d;
	rtps_pkg::best_t  pick;

	// local decode
	assign occ     = rtps_pkg::idx_to_cnt(cell_idx) < ctl.count;
	assign hit     = ctl.sel == cell_idx;
	assign is_zero = entry_q.rel_cnt == 16'd0;
	assign cand_d  = occ && entry_q.runnable && is_zero && (entry_q.prio <= ctl.limit);

	// keep the incoming best unless this entry is ready, within the priority limit and no worse
	always_comb begin
		pick = best_in;
		if (cand_q && (!best_in.found || entry_q.prio <= best_in.prio)) begin
			pick.found = 1'b1;
			pick.prio  = entry_q.prio;
			pick.idx   = cell_idx;
		end
	end

	// entry storage and search stage
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			rtps_pkg::OP_TICK: begin
				cand_q <= cand_d;
				if (occ && entry_q.runnable) begin
					if (is_zero) begin
						entry_q.state <= rtps_pkg::ST_READY;
					end else begin
						entry_q.rel_cnt <= entry_q.rel_cnt - {8'd0, ctl.step};
						entry_q.state   <= rtps_pkg::ST_SUSPENDED;
					end
				end
			end
			rtps_pkg::OP_ADD: begin
				if (hit) begin
					entry_q <= ctl.add_entry;
				end
			end
			rtps_pkg::OP_SHIFT: begin
				if (cell_idx >= ctl.sel) begin
					entry_q <= nbr;
				end
			end
			rtps_pkg::OP_SCAN: begin
				if (hit) begin
					best_q <= pick;
				end
			end
			rtps_pkg::OP_WIN: begin
				if (hit) begin
					if (entry_q.period != 16'd0) begin
						entry_q.rel_cnt <= entry_q.period;
					end
					if (ctl.run_win) begin
						entry_q.state <= rtps_pkg::ST_RUNNING;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign entry    = entry_q;
	assign best_out = best_q;

endmodule

`default_nettype wire

>>> rtl/rtps_apb_regs.sv
// configuration registers behind the APB-style port
`default_nettype none

module rtps_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rtps_pkg::APB_AW-1:0]   paddr,
	input  wire logic [rtps_pkg::APB_DW-1:0]   pwdata,
	output logic      [rtps_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output rtps_pkg::cfg_t                     cfg
);

	rtps_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register write, word bit selects the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit <= 8'd255;
			cfg_q.step  <= 8'd1;
		end else if (wr_en) begin
			unique case (paddr[2])
				rtps_pkg::REG_LIMIT: cfg_q.limit <= pwdata[7:0];
				rtps_pkg::REG_STEP:  cfg_q.step  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			rtps_pkg::REG_LIMIT: prdata = {24'd0, cfg_q.limit};
			rtps_pkg::REG_STEP:  prdata = {24'd0, cfg_q.step};
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire
